[rtl/core/pbauc_pkg.sv]
package pbauc_pkg;

  localparam int unsigned TIME_W      = 24;
  localparam int unsigned CONC_W      = 24;
  localparam int unsigned SUM_W       = CONC_W + 1;
  localparam int unsigned PROD_W      = TIME_W + SUM_W;
  localparam int unsigned AREA_W      = 56;
  localparam int unsigned NUM_CUTOFFS = 6;
  localparam int unsigned SLOT_W      = 3;
  localparam int unsigned MAX_SAMPLES = 1024;
  localparam int unsigned CNT_W       = 10;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam int unsigned MUL_STEPS   = TIME_W;
  localparam int unsigned STEP_W      = $clog2(MUL_STEPS + 1);

  localparam logic [CFG_IDX_W-1:0] REG_INJ_IDX   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CUT_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CUT_TIME0 = 3'd2;

  localparam logic [TIME_W-1:0] CUT0_RESET = 24'd60;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_CHECK,
    ST_CROSS_MUL,
    ST_CROSS_EMIT,
    ST_DT_MUL,
    ST_UPDATE,
    ST_FIN,
    ST_FILL,
    ST_STATUS
  } auc_state_e;

  typedef struct packed {
    logic                     start;
    logic signed [SUM_W-1:0]  mcand;
    logic [TIME_W-1:0]        mplier;
  } mul_req_t;

  typedef struct packed {
    logic                     busy;
    logic signed [PROD_W-1:0] product;
  } mul_rsp_t;

endpackage

[rtl/core/pbauc_ser_mul.sv]
module pbauc_ser_mul
  import pbauc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  logic signed [SUM_W-1:0] mcand_q, mcand_d;
  logic signed [SUM_W:0]   hi_q, hi_d;
  logic [TIME_W-1:0]       lo_q, lo_d;
  logic [STEP_W-1:0]       cnt_q, cnt_d;
  logic                    busy_q, busy_d;
  logic signed [SUM_W:0]   hi_add;

  // one multiplier bit per cycle, lsb first, arithmetic shift right
  always_comb begin
    hi_add  = lo_q[0] ? hi_q + (SUM_W+1)'(mcand_q) : hi_q;
    mcand_d = mcand_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    if (req_i.start) begin
      mcand_d = req_i.mcand;
      hi_d    = '0;
      lo_d    = req_i.mplier;
      cnt_d   = STEP_W'(MUL_STEPS);
      busy_d  = 1'b1;
    end else if (busy_q) begin
      hi_d   = {hi_add[SUM_W], hi_add[SUM_W:1]};
      lo_d   = {hi_add[0], lo_q[TIME_W-1:1]};
      cnt_d  = cnt_q - STEP_W'(1);
      busy_d = (cnt_q != STEP_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q <= mcand_d;
    hi_q    <= hi_d;
    lo_q    <= lo_d;
  end

  assign rsp_o.busy    = busy_q;
  assign rsp_o.product = {hi_q[SUM_W-1:0], lo_q};

endmodule

[rtl/core/post_bolus_area_under_curve.sv]
// a pre-injection sample passes PREP and FIN; an integrated sample adds CHECK,
//   DT_MUL and UPDATE, plus CROSS_MUL/CROSS_EMIT per cutoff crossed; a final sample
//   then emits a result per unreached cutoff, then the status; output stalls hold it
// one sample in flight at a time; each product goes through the bit-serial
//   multiplier at one bit per cycle
// reset: registers to their defaults, series state cleared, nothing pending
module post_bolus_area_under_curve
  import pbauc_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [TIME_W-1:0]          sample_time_i,
  input  logic signed [CONC_W-1:0]   concentration_i,
  input  logic                       end_of_series_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       result_kind_o,
  output logic [SLOT_W-1:0]          cutoff_slot_o,
  output logic signed [AREA_W-1:0]   area_value_o,
  output logic                       reached_o,
  output logic                       enhancing_o,
  output logic                       last_of_run_o
);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES - 1);
  localparam logic signed [AREA_W-1:0] AREA_MAX = {1'b0, {(AREA_W-1){1'b1}}};
  localparam logic signed [AREA_W-1:0] AREA_MIN = {1'b1, {(AREA_W-1){1'b0}}};

  // configuration
  logic [CNT_W-1:0]  inj_idx_q;
  logic [SLOT_W-1:0] cut_count_q;
  logic [TIME_W-1:0] cut_q [NUM_CUTOFFS];

  // series state
  auc_state_e               state_q, state_d;
  logic [TIME_W-1:0]        prev_time_q, bolus_time_q;
  logic signed [CONC_W-1:0] prev_conc_q;
  logic signed [AREA_W-1:0] run_area_q;
  logic [SLOT_W-1:0]        next_q;
  logic [CNT_W-1:0]         sample_cnt_q;
  logic                     all_pos_q, integ_q;

  // per-sample working registers
  logic [TIME_W-1:0]        t_q, dt_q, el_q, pel_q;
  logic signed [CONC_W-1:0] c_q;
  logic                     eos_q, follow_q;
  logic signed [SUM_W-1:0]  sum_q;

  logic                     out_valid_q;
  logic                     kind_q, reached_q, enh_q, last_q;
  logic [SLOT_W-1:0]        slot_q;
  logic signed [AREA_W-1:0] area_q;

  logic [SLOT_W-1:0]        count, next_inc, rd_idx;
  logic [TIME_W-1:0]        cut_rd, w;
  logic                     cut_cross, out_free, emit_req, more_fill;
  logic signed [AREA_W:0]   area_sum;
  logic signed [AREA_W-1:0] area_sat;
  mul_req_t                 mul_req;
  mul_rsp_t                 mul_rsp;

  pbauc_ser_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  always_comb begin
    if (cut_count_q == '0) begin
      count = SLOT_W'(1);
    end else if (cut_count_q > SLOT_W'(NUM_CUTOFFS)) begin
      count = SLOT_W'(NUM_CUTOFFS);
    end else begin
      count = cut_count_q;
    end
  end

  // single cutoff read port: current slot when checking, the following one otherwise
  assign next_inc = next_q + SLOT_W'(1);
  assign rd_idx   = (state_q == ST_CHECK) ? next_q : next_inc;
  assign cut_rd   = (rd_idx < SLOT_W'(NUM_CUTOFFS)) ? cut_q[rd_idx] : '0;

  assign cut_cross = (next_q < count) && (el_q > cut_rd);
  assign w         = (cut_rd > pel_q) ? cut_rd - pel_q : '0;
  assign more_fill = next_q < count;
  assign out_free  = !out_valid_q || !out_stall_i;

  // running area plus half product, floor rounding, saturated
  assign area_sum = (AREA_W+1)'(run_area_q) + (AREA_W+1)'(mul_rsp.product >>> 1);
  always_comb begin
    if (area_sum > (AREA_W+1)'(AREA_MAX)) begin
      area_sat = AREA_MAX;
    end else if (area_sum < (AREA_W+1)'(AREA_MIN)) begin
      area_sat = AREA_MIN;
    end else begin
      area_sat = area_sum[AREA_W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:       if (in_valid_i) state_d = ST_PREP;
      ST_PREP:       state_d = integ_q ? ST_CHECK : ST_FIN;
      ST_CHECK:      state_d = cut_cross ? ST_CROSS_MUL : ST_DT_MUL;
      ST_CROSS_MUL:  if (!mul_rsp.busy) state_d = ST_CROSS_EMIT;
      ST_CROSS_EMIT: if (out_free) state_d = ST_CHECK;
      ST_DT_MUL:     if (!mul_rsp.busy) state_d = ST_UPDATE;
      ST_UPDATE:     state_d = ST_FIN;
      ST_FIN:        state_d = eos_q ? ST_FILL : ST_IDLE;
      ST_FILL:       if (!more_fill) state_d = ST_STATUS;
      ST_STATUS:     if (out_free) state_d = ST_IDLE;
      default:       state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o     = (state_q != ST_IDLE);
    mul_req.start  = (state_q == ST_CHECK);
    mul_req.mcand  = sum_q;
    mul_req.mplier = cut_cross ? w : dt_q;
    emit_req       = (state_q == ST_CROSS_EMIT) || (state_q == ST_STATUS) ||
                     ((state_q == ST_FILL) && more_fill);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inj_idx_q   <= '0;
      cut_count_q <= SLOT_W'(1);
      for (int i = 0; i < NUM_CUTOFFS; i++) begin
        cut_q[i] <= (i == 0) ? CUT0_RESET : '0;
      end
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_INJ_IDX) begin
        inj_idx_q <= cfg_wdata_i[CNT_W-1:0];
      end else if (cfg_index_i == REG_CUT_COUNT) begin
        cut_count_q <= cfg_wdata_i[SLOT_W-1:0];
      end else if ((cfg_index_i - REG_CUT_TIME0) < CFG_IDX_W'(NUM_CUTOFFS)) begin
        cut_q[cfg_index_i - REG_CUT_TIME0] <= cfg_wdata_i[TIME_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      prev_time_q  <= '0;
      prev_conc_q  <= '0;
      bolus_time_q <= '0;
      run_area_q   <= '0;
      next_q       <= '0;
      sample_cnt_q <= '0;
      all_pos_q    <= 1'b1;
      integ_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_free) begin
        out_valid_q <= emit_req;
      end
      unique case (state_q)
        ST_PREP: begin
          if (!integ_q) begin
            if (sample_cnt_q == inj_idx_q) begin
              integ_q      <= 1'b1;
              bolus_time_q <= t_q;
              run_area_q   <= '0;
              next_q       <= '0;
            end else if (sample_cnt_q < CNT_MAX) begin
              sample_cnt_q <= sample_cnt_q + CNT_W'(1);
            end
          end
          prev_time_q <= t_q;
          prev_conc_q <= c_q;
        end
        ST_CROSS_EMIT: begin
          if (out_free) begin
            next_q <= next_inc;
            if (area_sat[AREA_W-1] || (area_sat == '0)) all_pos_q <= 1'b0;
          end
        end
        ST_UPDATE: run_area_q <= area_sat;
        ST_FILL: begin
          if (more_fill && out_free) begin
            next_q    <= next_inc;
            all_pos_q <= 1'b0;
          end
        end
        ST_STATUS: begin
          if (out_free) begin
            prev_time_q  <= '0;
            prev_conc_q  <= '0;
            bolus_time_q <= '0;
            run_area_q   <= '0;
            next_q       <= '0;
            sample_cnt_q <= '0;
            all_pos_q    <= 1'b1;
            integ_q      <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && in_valid_i) begin
      t_q   <= sample_time_i;
      c_q   <= concentration_i;
      eos_q <= end_of_series_i;
    end
    if (state_q == ST_PREP) begin
      sum_q <= SUM_W'(c_q) + SUM_W'(prev_conc_q);
      dt_q  <= (t_q >= prev_time_q) ? t_q - prev_time_q : '0;
      el_q  <= (t_q >= bolus_time_q) ? t_q - bolus_time_q : '0;
      pel_q <= (prev_time_q >= bolus_time_q) ? prev_time_q - bolus_time_q : '0;
    end
    // look ahead one slot while the product is being formed
    if (state_q == ST_CROSS_MUL) begin
      follow_q <= ({1'b0, next_q} + 4'd1 < {1'b0, count}) && (el_q > cut_rd);
    end
    if (emit_req && out_free) begin
      unique case (state_q)
        ST_CROSS_EMIT: begin
          kind_q    <= 1'b0;
          slot_q    <= next_q;
          area_q    <= area_sat;
          reached_q <= 1'b1;
          enh_q     <= 1'b0;
          last_q    <= !eos_q && !follow_q;
        end
        ST_FILL: begin
          kind_q    <= 1'b0;
          slot_q    <= next_q;
          area_q    <= '0;
          reached_q <= 1'b0;
          enh_q     <= 1'b0;
          last_q    <= 1'b0;
        end
        default: begin
          kind_q    <= 1'b1;
          slot_q    <= '0;
          area_q    <= '0;
          reached_q <= 1'b0;
          enh_q     <= all_pos_q;
          last_q    <= 1'b1;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_kind_o = kind_q;
  assign cutoff_slot_o = slot_q;
  assign area_value_o  = area_q;
  assign reached_o     = reached_q;
  assign enhancing_o   = enh_q;
  assign last_of_run_o = last_q;

endmodule
